/* rtl/core/tslf_pkg.sv */
// Shared types, constants and helper functions for the text stream line filter.
`timescale 1ns / 1ps
`default_nettype none
package tslf_pkg;

  localparam int NUM_DIGITS = 6;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int POS_W      = $clog2(NUM_DIGITS + 3);
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [POS_W-1:0] TAB_POS   = POS_W'(NUM_DIGITS);
  localparam logic [POS_W-1:0] BODY0_POS = POS_W'(NUM_DIGITS + 1);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(NUM_DIGITS + 2);

  localparam logic [REG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MARK_ENDS        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CARET_OFS = 8'd64;
  localparam logic [7:0] CTRL_MAX  = 8'd31;

  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic mark_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic             has_num;
    logic             two;
    logic [BCD_W-1:0] bcd;
    logic [7:0]       body_first;
    logic [7:0]       body_second;
  } job_t;

  function automatic logic [BCD_W-1:0] bcd_inc_sat(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] res;
    logic             carry;
    logic [3:0]       d;
    res   = v;
    carry = 1'b1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      d = v[4*k +: 4];
      if (carry) begin
        if (d < 4'd9) begin
          res[4*k +: 4] = d + 4'd1;
          carry = 1'b0;
        end else begin
          res[4*k +: 4] = 4'd0;
        end
      end
    end
    if (carry) begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [7:0] num_char(input logic [BCD_W-1:0] bcd,
                                          input logic [POS_W-1:0] p);
    logic       lead;
    logic [3:0] d;
    logic [7:0] ch;
    lead = 1'b1;
    ch   = CH_SPACE;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      d = bcd[4*k +: 4];
      if (d > 4'd9) begin
        d = 4'd9;
      end
      if (lead && d == 4'd0 && k > 0) begin
        if (k == NUM_DIGITS - 1 - int'(p)) begin
          ch = CH_SPACE;
        end
      end else begin
        lead = 1'b0;
        if (k == NUM_DIGITS - 1 - int'(p)) begin
          ch = CH_ZERO + {4'd0, d};
        end
      end
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/text_stream_line_filter_core.sv */
// Top level of the text stream line filter.
//
//  Channel   Direction  Contents
//  s_*       in         tdata = data_byte, tuser = first_of_file
//  m_*       out        tdata = out_byte, tlast = last
//  p*        in/out     register bus, six 1-bit registers at byte address 4*i
//
// One input byte per cycle when it makes one output byte and m_tready is high;
// bytes pass the job register, then the output register. A byte opening a numbered
// line makes up to nine output bytes and holds the input until the last is loaded.
// A stall on m_tready propagates back to s_tready through the job register.
// Reset clears the configuration and the valid flags, sets the line counter to 1
// and marks a line start.
`timescale 1ns / 1ps
`default_nettype none
module text_stream_line_filter_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // data_byte[7:0]
  input  wire logic                        s_tuser,   // first_of_file
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [7:0]                  m_tdata,   // out_byte[7:0]
  output logic                             m_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tslf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import tslf_pkg::*;

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic job_done;

  tslf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tslf_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_done  (job_done),
    .job_valid (job_valid),
    .job       (job)
  );

  tslf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_done  (job_done),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

/* rtl/core/tslf_cfg.sv */
// Configuration register file with its register-bus port.
`timescale 1ns / 1ps
`default_nettype none
module tslf_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tslf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output tslf_pkg::cfg_t                    cfg
);
  import tslf_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= pwdata[0];
        REG_NUMBER_ALL:       cfg.number_all       <= pwdata[0];
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= pwdata[0];
        REG_MARK_ENDS:        cfg.mark_ends        <= pwdata[0];
        REG_SHOW_TABS:        cfg.show_tabs        <= pwdata[0];
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_NUMBER_NONBLANK:  prdata[0] = cfg.number_nonblank;
      REG_NUMBER_ALL:       prdata[0] = cfg.number_all;
      REG_SQUEEZE_BLANK:    prdata[0] = cfg.squeeze_blank;
      REG_MARK_ENDS:        prdata[0] = cfg.mark_ends;
      REG_SHOW_TABS:        prdata[0] = cfg.show_tabs;
      REG_SHOW_NONPRINTING: prdata[0] = cfg.show_nonprinting;
      default:              prdata    = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/tslf_decode.sv */
// Input stage: line state, line counter and per-byte job register.
`timescale 1ns / 1ps
`default_nettype none
module tslf_decode (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tslf_pkg::cfg_t cfg,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [7:0]     s_tdata,
  input  wire logic           s_tuser,
  input  wire logic           job_done,
  output logic                job_valid,
  output tslf_pkg::job_t      job
);
  import tslf_pkg::*;

  logic             at_line_start, at_line_start_next;
  logic             prev_line_empty, prev_line_empty_next;
  logic [BCD_W-1:0] line_number_bcd, line_number_bcd_next;
  logic [BCD_W-1:0] num0;
  logic             als0, ple0, empty, squeeze, number, accept;
  job_t             job_next;

  assign s_tready = ~job_valid | job_done;
  assign accept   = s_tvalid & s_tready;

  always_comb begin
    num0    = s_tuser ? BCD_ONE : line_number_bcd;
    als0    = s_tuser | at_line_start;
    ple0    = s_tuser ? 1'b0 : prev_line_empty;
    empty   = (s_tdata == CH_LF);
    squeeze = als0 & cfg.squeeze_blank & empty & ple0;
    number  = als0 & (cfg.number_nonblank ? ~empty : cfg.number_all);

    if (squeeze) begin
      at_line_start_next   = als0;
      prev_line_empty_next = ple0;
      line_number_bcd_next = num0;
    end else begin
      at_line_start_next   = empty;
      prev_line_empty_next = als0 ? empty : ple0;
      line_number_bcd_next = number ? bcd_inc_sat(num0) : num0;
    end

    job_next.has_num     = number;
    job_next.bcd         = num0;
    job_next.two         = 1'b0;
    job_next.body_first  = CH_CARET;
    job_next.body_second = s_tdata;
    priority if (cfg.show_tabs && s_tdata == CH_TAB) begin
      job_next.two         = 1'b1;
      job_next.body_second = CH_I;
    end else if (cfg.mark_ends && (s_tdata == CH_LF || s_tdata == CH_CR)) begin
      job_next.two        = 1'b1;
      job_next.body_first = CH_DOLLAR;
    end else if (cfg.show_nonprinting && s_tdata <= CTRL_MAX && s_tdata != CH_LF
                 && s_tdata != CH_CR && s_tdata != CH_TAB) begin
      job_next.two         = 1'b1;
      job_next.body_second = s_tdata + CARET_OFS;
    end else if (cfg.show_nonprinting && s_tdata == CH_DEL) begin
      job_next.two         = 1'b1;
      job_next.body_second = CH_QMARK;
    end else begin
      job_next.two = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start   <= 1'b1;
      prev_line_empty <= 1'b0;
      line_number_bcd <= BCD_ONE;
      job_valid       <= 1'b0;
    end else begin
      if (accept) begin
        at_line_start   <= at_line_start_next;
        prev_line_empty <= prev_line_empty_next;
        line_number_bcd <= line_number_bcd_next;
        job_valid       <= ~squeeze;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tslf_emit.sv */
// Output sequencer: walks the prefix and body bytes of a job into the output register.
`timescale 1ns / 1ps
`default_nettype none
module tslf_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire tslf_pkg::job_t job,
  output logic                job_done,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import tslf_pkg::*;

  logic             started;
  logic [POS_W-1:0] pos, cur_pos, pos_next, body_pos;
  logic             load;
  logic [7:0]       byte_next;

  assign body_pos = job.two ? BODY0_POS : LAST_POS;
  assign cur_pos  = started ? pos : (job.has_num ? '0 : body_pos);
  assign load     = job_valid & (~m_tvalid | m_tready);
  assign job_done = load & (cur_pos == LAST_POS);
  assign pos_next = (cur_pos == TAB_POS) ? body_pos : cur_pos + POS_W'(1);

  always_comb begin
    priority if (cur_pos < TAB_POS) begin
      byte_next = num_char(job.bcd, cur_pos);
    end else if (cur_pos == TAB_POS) begin
      byte_next = CH_TAB;
    end else if (cur_pos == BODY0_POS) begin
      byte_next = job.body_first;
    end else begin
      byte_next = job.body_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        started  <= ~job_done;
        pos      <= pos_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_next;
      m_tlast <= job_done;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    started |-> (pos != '0 && pos <= LAST_POS))
    else $error("sequencer position out of range");

  a_started_has_job: assert property (@(posedge clk) disable iff (rst)
    started |-> job_valid)
    else $error("sequencer running without a job");

  a_last_on_done: assert property (@(posedge clk) disable iff (rst)
    job_done |=> (m_tvalid && m_tlast))
    else $error("final byte of a job not marked last");

  a_no_mid_job_last: assert property (@(posedge clk) disable iff (rst)
    (load && !job_done) |=> (m_tvalid && !m_tlast && started))
    else $error("intermediate byte marked last");

endmodule
`default_nettype wire

/* verif/text_stream_line_filter_core_test.sv */
// Self-checking testbench for the text stream line filter core.
`timescale 1ns / 1ps
module text_stream_line_filter_core_test;
  import tslf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  // Predicts the filtered byte stream and checks what the core emits.
  class filtered_text_model;
    cfg_t        cfg;
    bit          at_start;
    bit          prev_blank;
    int unsigned next_number;
    int unsigned count_max;
    logic [7:0]  burst[$];
    text_beat_t  due_bytes[$];
    int          mismatches;

    function new();
      cfg         = '0;
      at_start    = 1'b1;
      prev_blank  = 1'b0;
      next_number = 1;
      count_max   = 1;
      repeat (NUM_DIGITS) count_max *= 10;
      count_max -= 1;
      mismatches = 0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", what);
      end
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic v);
      case (idx)
        REG_NUMBER_NONBLANK:  cfg.number_nonblank  = v;
        REG_NUMBER_ALL:       cfg.number_all       = v;
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    = v;
        REG_MARK_ENDS:        cfg.mark_ends        = v;
        REG_SHOW_TABS:        cfg.show_tabs        = v;
        REG_SHOW_NONPRINTING: cfg.show_nonprinting = v;
        default: ;
      endcase
    endfunction

    function int waiting();
      return due_bytes.size();
    endfunction

    function void take_byte(logic [7:0] b, logic first);
      bit         blank;
      string      digits;
      logic [7:0] ch;
      ch = b;
      burst.delete();
      if (first) begin
        next_number = 1;
        at_start    = 1'b1;
        prev_blank  = 1'b0;
      end
      if (at_start) begin
        blank = (b == CH_LF);
        // A blank line right after another blank line is dropped entirely.
        if (cfg.squeeze_blank && blank && prev_blank) begin
          return;
        end
        prev_blank = blank;
        if (cfg.number_nonblank ? !blank : cfg.number_all) begin
          digits = $sformatf("%0d", next_number);
          for (int k = digits.len(); k < NUM_DIGITS; k++) burst.push_back(CH_SPACE);
          for (int k = 0; k < digits.len(); k++) burst.push_back(digits[k]);
          burst.push_back(CH_TAB);
          if (next_number < count_max) begin
            next_number++;
          end
        end
      end
      at_start = (b == CH_LF);
      if (cfg.show_tabs && b == CH_TAB) begin
        burst.push_back(CH_CARET);
        burst.push_back(CH_I);
      end else begin
        if (cfg.mark_ends && (b == CH_LF || b == CH_CR)) begin
          burst.push_back(CH_DOLLAR);
        end
        if (cfg.show_nonprinting) begin
          if (b <= CTRL_MAX && b != CH_LF && b != CH_CR && b != CH_TAB) begin
            burst.push_back(CH_CARET);
            ch = b + CARET_OFS;
          end else if (b == CH_DEL) begin
            burst.push_back(CH_CARET);
            ch = CH_QMARK;
          end
        end
        burst.push_back(ch);
      end
      foreach (burst[i]) begin
        due_bytes.push_back('{ch: burst[i], last: (i == burst.size() - 1)});
      end
    endfunction

    function void check_byte(logic [7:0] ch, logic last);
      text_beat_t want;
      if (due_bytes.size() == 0) begin
        report($sformatf("Unexpected output byte %h with last %b.", ch, last));
        return;
      end
      want = due_bytes.pop_front();
      if (want.ch !== ch || want.last !== last) begin
        report($sformatf("Output mismatch: expected byte %h last %b, got byte %h last %b.",
                         want.ch, want.last, ch, last));
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // data_byte[7:0]
  logic                s_tuser;   // first_of_file
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;   // out_byte[7:0]
  logic                m_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  filtered_text_model book = new();
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 cycle_count;

  text_stream_line_filter_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        book.check_byte(m_tdata, m_tlast);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic v);
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {31'd0, v};
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic [REG_IDX_W-1:0] idx, logic v);
    paddr   <= ADDR_W'({idx, 2'b00});
    pwrite  <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'd0, v}) begin
      book.report($sformatf("Register %0d read back %h, expected %h.", idx, prdata, v));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_NUMBER_NONBLANK, c.number_nonblank);
    write_reg(REG_NUMBER_ALL, c.number_all);
    write_reg(REG_SQUEEZE_BLANK, c.squeeze_blank);
    write_reg(REG_MARK_ENDS, c.mark_ends);
    write_reg(REG_SHOW_TABS, c.show_tabs);
    write_reg(REG_SHOW_NONPRINTING, c.show_nonprinting);
    check_reg(REG_NUMBER_NONBLANK, c.number_nonblank);
    check_reg(REG_NUMBER_ALL, c.number_all);
    check_reg(REG_SQUEEZE_BLANK, c.squeeze_blank);
    check_reg(REG_MARK_ENDS, c.mark_ends);
    check_reg(REG_SHOW_TABS, c.show_tabs);
    check_reg(REG_SHOW_NONPRINTING, c.show_nonprinting);
  endtask

  task automatic send_byte(logic [7:0] b, logic first);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.take_byte(b, first);
  endtask

  // Stops sending and waits until every predicted byte has come out. Squeezed
  // lines leave nothing to wait for, so a settling wait then lets the core finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text_byte(int lf_pct);
    int r;
    r = $urandom_range(99);
    if (r < lf_pct) return CH_LF;
    if (r < lf_pct + 4) return CH_TAB;
    if (r < lf_pct + 7) return CH_CR;
    if (r < lf_pct + 11) return 8'($urandom_range(31));
    if (r < lf_pct + 13) return CH_DEL;
    if (r < lf_pct + 25) return 8'($urandom_range(255));
    return 8'($urandom_range(126, 32));
  endfunction

  task automatic send_text(int count, int lf_pct);
    int left;
    int run;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 5) begin
        run = $urandom_range(4, 2);
        repeat (run) send_byte(CH_LF, 1'b0);
        left -= run;
      end else begin
        send_byte(pick_text_byte(lf_pct), $urandom_range(99) < 2);
        left--;
      end
    end
  endtask

  initial begin
    cfg_t c;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    m_tready    = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cycle_count = 0;
    tx_idle_pct = 8;
    rx_idle_pct = 50;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plain pass-through with the reset configuration.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("A", 1'b0);
    send_byte(CH_LF, 1'b0);
    drain();

    // Everything on: nonblank numbering wins, blank lines are squeezed, tabs are
    // shown as caret I, CR and LF get an end mark and other control bytes are in caret notation.
    load_config('1);
    send_byte("a", 1'b1);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(CH_DEL, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte("b", 1'b0);
    send_byte(CH_LF, 1'b0);
    drain();

    // Every line numbered, end marks shown, tabs and control bytes raw.
    c = '0;
    c.number_all = 1'b1;
    c.mark_ends  = 1'b1;
    load_config(c);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_DEL, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte("z", 1'b1);
    send_byte(CH_LF, 1'b0);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tx_idle_pct = 50;
        rx_idle_pct = 8;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      c = 6'($urandom_range(63));
      if (p == 0) begin
        c = '1;
      end else if (p == 1) begin
        c = '0;
      end else if (p == 2) begin
        c.number_nonblank = 1'b0;
        c.number_all      = 1'b1;
      end
      load_config(c);
      if (p == 2) begin
        send_text(38, 15);
        drain();
        send_text(39, 15);
      end else begin
        send_text(77, (p == 3) ? 50 : 15);
      end
      drain();
    end

    if (book.waiting() != 0) begin
      book.report($sformatf("%0d output bytes never arrived.", book.waiting()));
    end
    if (book.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
